[hw/rtl/cnfr_pkg.sv]
// ----------------------------------------------------------------------------
// cnfr_pkg
// Types, codes and the CRC-8 update shared by the complemented-nibble frame
// receiver modules.
// ----------------------------------------------------------------------------
package cnfr_pkg;

  localparam logic [7:0] MarkStx    = 8'h02;
  localparam logic [7:0] MarkEtx    = 8'h03;
  localparam logic [3:0] NibbleMask = 4'hF;
  localparam logic [7:0] CrcPoly    = 8'h8C;

  localparam logic [7:0]  MaxLengthRst = 8'd255;
  localparam logic [15:0] TimeoutRst   = 16'd1000;
  localparam logic [15:0] TicksMax     = 16'hFFFF;

  localparam int CfgIdxW = 1;
  localparam int CfgDatW = 16;

  localparam logic [CfgIdxW-1:0] CfgMaxLength = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgTimeoutMs = 1'b1;

  localparam int QDepth = 2;
  localparam int QAw    = $clog2(QDepth);
  localparam int QCntW  = QAw + 1;

  localparam logic KindPayload = 1'b0;
  localparam logic KindEnd     = 1'b1;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StBadChar  = 3'd1;
  localparam logic [2:0] StBadCrc   = 3'd2;
  localparam logic [2:0] StOverflow = 3'd3;
  localparam logic [2:0] StTimeout  = 3'd4;

  typedef enum logic [1:0] {
    OpByte  = 2'd0,
    OpTick  = 2'd1,
    OpStart = 2'd2,
    OpRsvd  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ClStart = 3'd0,
    ClTick  = 3'd1,
    ClStx   = 3'd2,
    ClEtx   = 3'd3,
    ClData  = 3'd4,
    ClBad   = 3'd5
  } cls_e;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [7:0] index;
    logic [2:0] status;
    logic [7:0] length;
  } out_item_t;

  typedef struct packed {
    cls_e       cls;
    logic [3:0] nibble;
  } cls_item_t;

  typedef struct packed {
    logic               valid;
    logic [CfgIdxW-1:0] index;
    logic [CfgDatW-1:0] data;
  } cfg_wr_t;

  function automatic logic [7:0] crc_fold(logic [7:0] crc_in, logic [7:0] b_in);
    logic [7:0] crc;
    logic [7:0] b;
    logic       mix;
    crc = crc_in;
    b   = b_in;
    for (int k = 0; k < 8; k++) begin
      mix = crc[0] ^ b[0];
      crc = crc >> 1;
      if (mix) begin
        crc = crc ^ CrcPoly;
      end
      b = b >> 1;
    end
    return crc;
  endfunction

endpackage

[hw/rtl/cnfr_front.sv]
// ----------------------------------------------------------------------------
// cnfr_front
// Input side: takes line bytes, ticks and starts, classifies them and pushes
// them into the command queue.
// ----------------------------------------------------------------------------
module cnfr_front (
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  cnfr_pkg::in_item_t   in_data_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output cnfr_pkg::cls_item_t  q_item_o
);

  logic drop;

  always_comb begin
    drop             = 1'b0;
    q_item_o.nibble  = in_data_i.rx_byte[7:4];
    q_item_o.cls     = cnfr_pkg::ClData;
    case (cnfr_pkg::op_e'(in_data_i.op))
      cnfr_pkg::OpStart: q_item_o.cls = cnfr_pkg::ClStart;
      cnfr_pkg::OpTick:  q_item_o.cls = cnfr_pkg::ClTick;
      cnfr_pkg::OpByte: begin
        if (in_data_i.rx_byte == cnfr_pkg::MarkStx) begin
          q_item_o.cls = cnfr_pkg::ClStx;
        end else if (in_data_i.rx_byte == cnfr_pkg::MarkEtx) begin
          q_item_o.cls = cnfr_pkg::ClEtx;
        end else if (in_data_i.rx_byte[7:4] ==
                     (in_data_i.rx_byte[3:0] ^ cnfr_pkg::NibbleMask)) begin
          q_item_o.cls = cnfr_pkg::ClData;
        end else begin
          q_item_o.cls = cnfr_pkg::ClBad;
        end
      end
      default: drop = 1'b1;
    endcase
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && !drop;

endmodule

[hw/rtl/cnfr_queue.sv]
// ----------------------------------------------------------------------------
// cnfr_queue
// Short FIFO of classified items between the front and back sides.
// ----------------------------------------------------------------------------
module cnfr_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  cnfr_pkg::cls_item_t  item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output cnfr_pkg::cls_item_t  item_o
);

  cnfr_pkg::cls_item_t               mem_q [cnfr_pkg::QDepth];
  logic [cnfr_pkg::QAw-1:0]          wr_ptr_q, wr_ptr_d;
  logic [cnfr_pkg::QAw-1:0]          rd_ptr_q, rd_ptr_d;
  logic [cnfr_pkg::QCntW-1:0]        cnt_q, cnt_d;
  logic                              do_pop;

  assign full_o  = (cnt_q == cnfr_pkg::QCntW'(cnfr_pkg::QDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

[hw/rtl/cnfr_back.sv]
// ----------------------------------------------------------------------------
// cnfr_back
// Frame state, nibble pairing, CRC, length and timeout checks; holds the
// configuration registers and the output register.
// ----------------------------------------------------------------------------
module cnfr_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cnfr_pkg::cfg_wr_t    cfg_i,
  input  logic                 item_valid_i,
  input  cnfr_pkg::cls_item_t  item_i,
  output logic                 item_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output cnfr_pkg::out_item_t  out_data_o
);

  logic [7:0]  max_length_q;
  logic [15:0] timeout_ms_q;

  logic        armed_q, armed_d;
  logic        started_q, started_d;
  logic        end_seen_q, end_seen_d;
  logic [7:0]  pos_q, pos_d;
  logic        expect_hi_q, expect_hi_d;
  logic [3:0]  hi_nib_q, hi_nib_d;
  logic [7:0]  crc_q, crc_d;
  logic [15:0] ticks_q, ticks_d;

  logic                 out_valid_q, out_valid_d;
  cnfr_pkg::out_item_t  out_q, res;
  logic                 res_valid;
  logic                 take;
  logic [7:0]           full;
  logic [15:0]          ticks_inc;

  assign take       = item_valid_i && (!out_valid_q || !out_stall_i);
  assign item_pop_o = take;
  assign full       = {hi_nib_q, item_i.nibble};
  assign ticks_inc  = (ticks_q != cnfr_pkg::TicksMax) ? ticks_q + 16'd1 : ticks_q;

  always_comb begin
    armed_d     = armed_q;
    started_d   = started_q;
    end_seen_d  = end_seen_q;
    pos_d       = pos_q;
    expect_hi_d = expect_hi_q;
    hi_nib_d    = hi_nib_q;
    crc_d       = crc_q;
    ticks_d     = ticks_q;
    res_valid   = 1'b0;
    res         = '{kind: cnfr_pkg::KindEnd, data_byte: 8'd0, index: 8'd0,
                    status: cnfr_pkg::StOk, length: 8'd0};

    if (take) begin
      if (item_i.cls == cnfr_pkg::ClStart) begin
        armed_d     = 1'b1;
        started_d   = 1'b0;
        end_seen_d  = 1'b0;
        pos_d       = 8'd0;
        expect_hi_d = 1'b1;
        hi_nib_d    = 4'd0;
        crc_d       = 8'd0;
        ticks_d     = 16'd0;
      end else if (armed_q) begin
        case (item_i.cls)
          cnfr_pkg::ClTick: begin
            ticks_d = ticks_inc;
            if (ticks_inc >= timeout_ms_q) begin
              res_valid  = 1'b1;
              res.status = cnfr_pkg::StTimeout;
            end
          end
          cnfr_pkg::ClStx: begin
            started_d   = 1'b1;
            end_seen_d  = 1'b0;
            pos_d       = 8'd0;
            expect_hi_d = 1'b1;
            hi_nib_d    = 4'd0;
            crc_d       = 8'd0;
            ticks_d     = 16'd0;
          end
          cnfr_pkg::ClEtx: end_seen_d = 1'b1;
          cnfr_pkg::ClBad: begin
            if (started_q) begin
              res_valid  = 1'b1;
              res.status = cnfr_pkg::StBadChar;
            end
          end
          cnfr_pkg::ClData: begin
            if (started_q) begin
              if (expect_hi_q) begin
                hi_nib_d    = item_i.nibble;
                expect_hi_d = 1'b0;
              end else begin
                expect_hi_d = 1'b1;
                res_valid   = 1'b1;
                if (end_seen_q) begin
                  if (crc_q != full) begin
                    res.status = cnfr_pkg::StBadCrc;
                  end else begin
                    res.length = pos_q;
                  end
                end else if (pos_q >= max_length_q) begin
                  res.status = cnfr_pkg::StOverflow;
                end else begin
                  res.kind      = cnfr_pkg::KindPayload;
                  res.data_byte = full;
                  res.index     = pos_q;
                  crc_d         = cnfr_pkg::crc_fold(crc_q, full);
                  pos_d         = pos_q + 8'd1;
                end
              end
            end
          end
          default: ;
        endcase
        if (res_valid && res.kind == cnfr_pkg::KindEnd) begin
          armed_d   = 1'b0;
          started_d = 1'b0;
        end
      end
    end

    out_valid_d = out_valid_q && out_stall_i;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q <= cnfr_pkg::MaxLengthRst;
      timeout_ms_q <= cnfr_pkg::TimeoutRst;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == cnfr_pkg::CfgMaxLength) begin
        max_length_q <= cfg_i.data[7:0];
      end
      if (cfg_i.index == cnfr_pkg::CfgTimeoutMs) begin
        timeout_ms_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= 1'b0;
      started_q   <= 1'b0;
      end_seen_q  <= 1'b0;
      pos_q       <= 8'd0;
      expect_hi_q <= 1'b1;
      hi_nib_q    <= 4'd0;
      crc_q       <= 8'd0;
      ticks_q     <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      armed_q     <= armed_d;
      started_q   <= started_d;
      end_seen_q  <= end_seen_d;
      pos_q       <= pos_d;
      expect_hi_q <= expect_hi_d;
      hi_nib_q    <= hi_nib_d;
      crc_q       <= crc_d;
      ticks_q     <= ticks_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[hw/rtl/complemented_nibble_frame_receiver_unit.sv]
// Path: an input transfer is written into the queue; the back side then takes it
//   and registers its result, if any, in the output register when that is free.
// Throughput: 1 item per cycle while the queue is not full; the back side retires one queued item per cycle
//   while the output register is free or being drained.
// A 2-entry queue decouples input stall from output stall.
// Reset: asynchronous, active low; clears frame state, queue and output valid,
//   max_length to 255 and timeout_ms to 1000.
// ----------------------------------------------------------------------------
// complemented_nibble_frame_receiver_unit
// STX/ETX framed receiver with complemented-nibble coding and CRC-8 check.
// ----------------------------------------------------------------------------
module complemented_nibble_frame_receiver_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  cnfr_pkg::in_item_t                   in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output cnfr_pkg::out_item_t                  out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [cnfr_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [cnfr_pkg::CfgDatW-1:0]         cfg_data_i
);

  logic                 q_full, q_push, q_pop, q_valid;
  cnfr_pkg::cls_item_t  q_in, q_out;
  cnfr_pkg::cfg_wr_t    cfg_wr;

  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i && cfg_ready_o;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  cnfr_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (q_in)
  );

  cnfr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out)
  );

  cnfr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_wr),
    .item_valid_i (q_valid),
    .item_i       (q_out),
    .item_pop_o   (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

[hw/rtl/cnfr_checker.sv]
// ----------------------------------------------------------------------------
// cnfr_checker
// Port-level checks for the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module cnfr_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input cnfr_pkg::out_item_t                  out_data_o
);

  // a stalled result transfer keeps its valid and payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("output result dropped or changed under stall");

  a_payload_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind == cnfr_pkg::KindPayload) |->
    (out_data_o.status == cnfr_pkg::StOk && out_data_o.length == 8'd0))
    else $error("payload transfer carries status or length");

  a_end_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind == cnfr_pkg::KindEnd) |->
    (out_data_o.data_byte == 8'd0 && out_data_o.index == 8'd0 &&
     (out_data_o.status == cnfr_pkg::StOk || out_data_o.length == 8'd0)))
    else $error("end transfer carries payload fields");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status <= cnfr_pkg::StTimeout))
    else $error("status code out of range");

endmodule

bind complemented_nibble_frame_receiver_unit cnfr_checker u_cnfr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
